// ----- sv/exyz_pkg.sv -----
package exyz_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10680862,  32'sd5341781,
    32'sd2670675,   32'sd1335343,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

endpackage

// ----- sv/euler_xyz_vector_rotator_top.sv -----
// channel | handshake                  | word
// input   | in_valid, in_stall         | in_x, in_y, in_z, angle_x, angle_y, angle_z
// output  | out_valid, out_stall       | out_x, out_y, out_z
//
// One word per cycle while the output is not stalled. The three parallel CORDIC
// pipelines (one stage per step plus angle set-up and quadrant map) come first,
// then two stages (multiply, round and saturate) for each of the three rotations.
// Reset clears the valid bits only.
// The whole pipeline holds while the output word is stalled; in_stall follows.
module euler_xyz_vector_rotator_top #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic [15:0]        angle_x,
  input  logic [15:0]        angle_y,
  input  logic [15:0]        angle_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  import exyz_pkg::*;

  localparam int TW  = FRAC_BITS + 2;
  localparam int CL  = CORDIC_STEPS + 2;
  localparam int LAT = CL + 6;

  logic              en;
  logic [LAT-1:0]    vld;
  logic signed [31:0] vx [0:CL-1];
  logic signed [31:0] vy [0:CL-1];
  logic signed [31:0] vz [0:CL-1];
  logic signed [TW-1:0] cx, sx, cy, sy, cz, sz;
  logic signed [TW-1:0] cyd [0:1];
  logic signed [TW-1:0] syd [0:1];
  logic signed [TW-1:0] czd [0:3];
  logic signed [TW-1:0] szd [0:3];
  logic signed [TW-1:0] syn;
  logic signed [31:0] r1y, r1z, r1x, r2x, r2z, r2y;

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx[0] <= in_x;
      vy[0] <= in_y;
      vz[0] <= in_z;
      for (int i = 1; i < CL; i++) begin
        vx[i] <= vx[i-1];
        vy[i] <= vy[i-1];
        vz[i] <= vz[i-1];
      end
      cyd[0] <= cy;
      syd[0] <= sy;
      cyd[1] <= cyd[0];
      syd[1] <= syd[0];
      czd[0] <= cz;
      szd[0] <= sz;
      for (int i = 1; i < 4; i++) begin
        czd[i] <= czd[i-1];
        szd[i] <= szd[i-1];
      end
    end
  end

  exyz_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_trig_x (
    .clk(clk), .en(en), .angle(ANGLE_BITS'({8'h00, angle_x})), .cs(cx), .sn(sx)
  );
  exyz_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_trig_y (
    .clk(clk), .en(en), .angle(ANGLE_BITS'({8'h00, angle_y})), .cs(cy), .sn(sy)
  );
  exyz_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_trig_z (
    .clk(clk), .en(en), .angle(ANGLE_BITS'({8'h00, angle_z})), .cs(cz), .sn(sz)
  );

  exyz_rot #(.FRAC_BITS(FRAC_BITS)) u_rot_x (
    .clk(clk), .en(en), .a(vy[CL-1]), .b(vz[CL-1]), .pass(vx[CL-1]),
    .c(cx), .s(sx), .n1(r1y), .n2(r1z), .pass_out(r1x)
  );

  // rotation about y runs the other way round in the (x, z) plane
  assign syn = -syd[1];

  exyz_rot #(.FRAC_BITS(FRAC_BITS)) u_rot_y (
    .clk(clk), .en(en), .a(r1x), .b(r1z), .pass(r1y),
    .c(cyd[1]), .s(syn), .n1(r2x), .n2(r2z), .pass_out(r2y)
  );

  exyz_rot #(.FRAC_BITS(FRAC_BITS)) u_rot_z (
    .clk(clk), .en(en), .a(r2x), .b(r2y), .pass(r2z),
    .c(czd[3]), .s(szd[3]), .n1(out_x), .n2(out_y), .pass_out(out_z)
  );

endmodule

// ----- sv/exyz_cordic.sv -----
module exyz_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic signed [FRAC_BITS+1:0] cs,
  output logic signed [FRAC_BITS+1:0] sn
);
  import exyz_pkg::*;

  localparam int SH = 30 - FRAC_BITS;
  localparam int TW = FRAC_BITS + 2;

  logic signed [33:0] xs [0:CORDIC_STEPS];
  logic signed [33:0] ys [0:CORDIC_STEPS];
  logic signed [31:0] zs [0:CORDIC_STEPS];
  logic [1:0]         qs [0:CORDIC_STEPS];

  logic [31:0]        t;
  logic [31:0]        tq;
  logic [1:0]         q0;
  logic signed [33:0] xr;
  logic signed [33:0] yr;
  logic signed [TW-1:0] c;
  logic signed [TW-1:0] s;
  logic signed [TW-1:0] cs_next;
  logic signed [TW-1:0] sn_next;

  always_comb begin
    t  = {angle, {(32 - ANGLE_BITS){1'b0}}};
    tq = t + 32'h2000_0000;
    q0 = tq[31:30];
  end

  assign xs[0] = CORDIC_GAIN;
  assign ys[0] = '0;

  always_ff @(posedge clk) begin
    if (en) begin
      zs[0] <= t - {q0, 30'b0};
      qs[0] <= q0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][31]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_TAB[i];
        end
        qs[i+1] <= qs[i];
      end
    end
  end

  always_comb begin
    xr = (xs[CORDIC_STEPS] + (34'sd1 <<< (SH - 1))) >>> SH;
    yr = (ys[CORDIC_STEPS] + (34'sd1 <<< (SH - 1))) >>> SH;
    c  = xr[TW-1:0];
    s  = yr[TW-1:0];
    case (quad_t'(qs[CORDIC_STEPS]))
      QUAD_0: begin
        cs_next = c;
        sn_next = s;
      end
      QUAD_1: begin
        cs_next = -s;
        sn_next = c;
      end
      QUAD_2: begin
        cs_next = -c;
        sn_next = -s;
      end
      default: begin
        cs_next = s;
        sn_next = -c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs <= cs_next;
      sn <= sn_next;
    end
  end

endmodule

// ----- sv/exyz_rot.sv -----
module exyz_rot #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [31:0]          a,
  input  logic signed [31:0]          b,
  input  logic signed [31:0]          pass,
  input  logic signed [FRAC_BITS+1:0] c,
  input  logic signed [FRAC_BITS+1:0] s,
  output logic signed [31:0]          n1,
  output logic signed [31:0]          n2,
  output logic signed [31:0]          pass_out
);
  localparam int TW = FRAC_BITS + 2;
  localparam int PW = 32 + TW;
  localparam int SW = PW + 1;

  localparam logic signed [SW-1:0] MAXV = {{(SW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW - 31){1'b1}}, {31{1'b0}}};
  localparam logic signed [SW-1:0] RND  = {{(SW - 1){1'b0}}, 1'b1} <<< (FRAC_BITS - 1);

  logic signed [PW-1:0] p_ac;
  logic signed [PW-1:0] p_bs;
  logic signed [PW-1:0] p_as;
  logic signed [PW-1:0] p_bc;
  logic signed [31:0]   pass_d;
  logic signed [SW-1:0] r1;
  logic signed [SW-1:0] r2;
  logic signed [31:0]   n1_next;
  logic signed [31:0]   n2_next;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ac   <= a * c;
      p_bs   <= b * s;
      p_as   <= a * s;
      p_bc   <= b * c;
      pass_d <= pass;
    end
  end

  always_comb begin
    r1 = ($signed({p_ac[PW-1], p_ac}) - $signed({p_bs[PW-1], p_bs}) + RND) >>> FRAC_BITS;
    r2 = ($signed({p_as[PW-1], p_as}) + $signed({p_bc[PW-1], p_bc}) + RND) >>> FRAC_BITS;
    if (r1 > MAXV)      n1_next = 32'sh7fff_ffff;
    else if (r1 < MINV) n1_next = 32'sh8000_0000;
    else                n1_next = r1[31:0];
    if (r2 > MAXV)      n2_next = 32'sh7fff_ffff;
    else if (r2 < MINV) n2_next = 32'sh8000_0000;
    else                n2_next = r2[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1       <= n1_next;
      n2       <= n2_next;
      pass_out <= pass_d;
    end
  end

endmodule

// ----- sv/exyz_checker.sv -----
module exyz_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z
);

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output word");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output word shown straight after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output word dropped");

  a_word_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(out_x) && $stable(out_y) && $stable(out_z)))
    else $error("stalled output word changed");

endmodule

bind euler_xyz_vector_rotator_top exyz_checker u_exyz_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .out_x(out_x), .out_y(out_y), .out_z(out_z)
);
